// File: hw/rtl/pdvm_pkg.sv
// Shared constants and types for the perspective divide / viewport map block.
`timescale 1ns / 1ps
package pdvm_pkg;

	// Register indexes on the configuration port
	typedef enum logic [0:0] {
		CFG_VP_WIDTH  = 1'b0,
		CFG_VP_HEIGHT = 1'b1
	} cfg_idx_t;

	localparam int VP_BITS    = 13;  // viewport register width
	localparam int QUO_BITS   = 32;  // quotient bits produced by each divider
	localparam int COORD_BITS = 32;  // Q16.16 coordinate width
	localparam int MAG_BITS   = 33;  // coordinate after sign fold
	localparam int W_EPS_RAW  = 6;   // |w| at or below this raw value is rejected

	// Per-item flags carried alongside the divider pipeline
	typedef struct packed {
		logic ok;
		logic neg;
	} side_t;

endpackage

// File: hw/rtl/pdvm_div.sv
// Pipelined restoring divider, one quotient bit per stage, stall by enable.
`timescale 1ns / 1ps
module pdvm_div import pdvm_pkg::*; #(
	parameter int NW = 54,
	parameter int DW = 33
) (
	input  logic                clk,
	input  logic                en,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	output logic [QUO_BITS-1:0] quo
);
	localparam int HW = NW - QUO_BITS;

	logic [DW-1:0]       rem_s [0:QUO_BITS];
	logic [QUO_BITS-1:0] low_s [0:QUO_BITS];
	logic [QUO_BITS-1:0] quo_s [0:QUO_BITS];
	logic [DW-1:0]       den_s [0:QUO_BITS];

	// Entry stage: the high part of the numerator is already below den
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {{(DW-HW){1'b0}}, num[NW-1:QUO_BITS]};
			low_s[0] <= num[QUO_BITS-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
		end
	end

	// One shift, compare and subtract per stage
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;
		assign trial = {rem_s[i], low_s[i][QUO_BITS-1]};
		assign ge    = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? DW'(trial - {1'b0, den_s[i]}) : trial[DW-1:0];
				low_s[i+1] <= {low_s[i][QUO_BITS-2:0], 1'b0};
				quo_s[i+1] <= {quo_s[i][QUO_BITS-2:0], ge};
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign quo = quo_s[QUO_BITS];

endmodule

// File: hw/rtl/perspective_divide_viewport_map.sv
// Perspective divide, view-volume clip and viewport map, fully pipelined.
// Pipeline: 2 prep stages, 33 divider stages (an entry stage, then one per
// quotient bit) and 1 output register from input request to result.
// Throughput: one vertex per cycle; the whole pipe holds when the output stalls.
// Reset: valid bits clear, viewport registers load 640 x 480.
`timescale 1ns / 1ps
module perspective_divide_viewport_map import pdvm_pkg::*; #(
	parameter int MAX_VIEWPORT = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [VP_BITS-1:0]     cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [31:0]     clip_x,
	input  logic signed [31:0]     clip_y,
	input  logic signed [31:0]     clip_z,
	input  logic signed [31:0]     clip_w,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   visible,
	output logic [19:0]            screen_x,
	output logic [19:0]            screen_y,
	output logic [16:0]            depth,
	output logic signed [31:0]     inv_w
);
	localparam int DL  = QUO_BITS + 1;
	localparam int NXW = MAG_BITS + VP_BITS + 8;

	logic adv;
	logic [VP_BITS-1:0] vp_w_q, vp_h_q, wd, ht;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_w_q <= VP_BITS'(640);
			vp_h_q <= VP_BITS'(480);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VP_WIDTH:  vp_w_q <= cfg_data;
				CFG_VP_HEIGHT: vp_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign wd = (32'(vp_w_q) > 32'(MAX_VIEWPORT)) ? VP_BITS'(MAX_VIEWPORT) : vp_w_q;
	assign ht = (32'(vp_h_q) > 32'(MAX_VIEWPORT)) ? VP_BITS'(MAX_VIEWPORT) : vp_h_q;

	// Whole pipe advances unless the output holds an untaken result
	logic out_valid_q;
	assign adv      = ~out_valid_q | out_ready;
	assign in_ready = adv;

	// Stage 1: fold the sign of w into all coordinates
	logic v_s1, neg_s1;
	logic signed [MAG_BITS-1:0] x_s1, y_s1, z_s1, w_s1;
	logic neg_in;
	assign neg_in = clip_w[31];

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= neg_in;
			x_s1   <= neg_in ? -MAG_BITS'(clip_x) : MAG_BITS'(clip_x);
			y_s1   <= neg_in ? -MAG_BITS'(clip_y) : MAG_BITS'(clip_y);
			z_s1   <= neg_in ? -MAG_BITS'(clip_z) : MAG_BITS'(clip_z);
			w_s1   <= neg_in ? -MAG_BITS'(clip_w) : MAG_BITS'(clip_w);
		end
	end

	// Stage 2: volume tests and divider numerators
	logic v_s2;
	side_t side_s2;
	logic [NXW-1:0] nx_s2, ny_s2;
	logic [MAG_BITS-1:0] den2_s2;
	logic [47:0] nz_s2;
	logic [31:0] w_s2;
	logic ok_c;
	logic [MAG_BITS-1:0] sx, sy;

	assign ok_c = (w_s1 > MAG_BITS'(W_EPS_RAW)) &&
		(x_s1 >= -w_s1) && (x_s1 < w_s1) &&
		(y_s1 >= -w_s1) && (y_s1 < w_s1) &&
		(z_s1 >= 0) && (z_s1 <= w_s1) &&
		(wd != '0) && (ht != '0);
	assign sx = MAG_BITS'(x_s1 + w_s1);
	assign sy = MAG_BITS'(y_s1 + w_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2.ok  <= ok_c;
			side_s2.neg <= neg_s1;
			nx_s2   <= {(MAG_BITS+VP_BITS)'(sx) * (MAG_BITS+VP_BITS)'(wd), 8'b0};
			ny_s2   <= {(MAG_BITS+VP_BITS)'(sy) * (MAG_BITS+VP_BITS)'(ht), 8'b0};
			den2_s2 <= {w_s1[31:0], 1'b0};
			nz_s2   <= {z_s1[31:0], 16'b0};
			w_s2    <= w_s1[31:0];
		end
	end

	// Dividers
	logic [QUO_BITS-1:0] qx, qy, qz, qi;

	pdvm_div #(.NW(NXW), .DW(MAG_BITS)) u_div_x (
		.clk(clk), .en(adv), .num(nx_s2), .den(den2_s2), .quo(qx));
	pdvm_div #(.NW(NXW), .DW(MAG_BITS)) u_div_y (
		.clk(clk), .en(adv), .num(ny_s2), .den(den2_s2), .quo(qy));
	pdvm_div #(.NW(48), .DW(32)) u_div_z (
		.clk(clk), .en(adv), .num(nz_s2), .den(w_s2), .quo(qz));
	pdvm_div #(.NW(33), .DW(32)) u_div_i (
		.clk(clk), .en(adv), .num(33'h1_0000_0000), .den(w_s2), .quo(qi));

	// Flags ride alongside the divider stages
	side_t side_p [0:DL-1];
	always_ff @(posedge clk) begin
		if (adv) begin
			side_p[0] <= side_s2;
			for (int i = 1; i < DL; i++) side_p[i] <= side_p[i-1];
		end
	end

	// Valid bits
	logic [DL-1:0] v_p;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_p         <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_p         <= {v_p[DL-2:0], v_s2};
			out_valid_q <= v_p[DL-1];
		end
	end

	// Output register, fields zeroed on reject
	logic        vis_q;
	logic [19:0] sx_q, sy_q;
	logic [16:0] dp_q;
	logic [31:0] iw_q;
	side_t       side_e;
	assign side_e = side_p[DL-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			vis_q <= side_e.ok;
			sx_q  <= side_e.ok ? qx[19:0] : '0;
			sy_q  <= side_e.ok ? qy[19:0] : '0;
			dp_q  <= side_e.ok ? qz[16:0] : '0;
			iw_q  <= side_e.ok ? (side_e.neg ? -qi : qi) : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign visible   = vis_q;
	assign screen_x  = sx_q;
	assign screen_y  = sy_q;
	assign depth     = dp_q;
	assign inv_w     = iw_q;

endmodule
